// File: rtl/mtnt_pkg.sv
// ----------------------------------------------------------------------------
// mtnt_pkg: shared types and constants for the MIDI track note transposer
// Byte-level status codes and the per-byte result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mtnt_pkg;

  localparam int BYTE_W = 8;
  localparam int SKIP_W = 28;

  typedef logic [BYTE_W-1:0] byte_t;

  // result of parsing one track byte
  typedef struct packed {
    byte_t byte_val;
    logic  was_note;
  } mtnt_res_t;

  localparam byte_t ST_META     = 8'hFF;
  localparam byte_t ST_SYSEX_END = 8'hF7;

  // status high nibbles
  localparam logic [3:0] NIB_SYS     = 4'hF;
  localparam logic [3:0] NIB_BEND    = 4'hE;
  localparam logic [3:0] NIB_CHPRESS = 4'hD;
  localparam logic [3:0] NIB_PROG    = 4'hC;
  localparam logic [3:0] NIB_CTRL    = 4'hB;
  localparam logic [3:0] NIB_POLY    = 4'hA;
  localparam logic [3:0] NIB_NOTE_ON = 4'h9;
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;

endpackage

`default_nettype wire

// File: rtl/mtnt_parser.sv
// ----------------------------------------------------------------------------
// mtnt_parser: track event parser state and note byte transposition
// Holds parse phase, running status class and meta skip count; produces
// the output byte for the beat presented and updates state on advance.
// ----------------------------------------------------------------------------
`default_nettype none

module mtnt_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire mtnt_pkg::byte_t   byte_in,
  input  wire logic              last_in,
  input  wire mtnt_pkg::byte_t   note_shift,
  output mtnt_pkg::mtnt_res_t    res
);
  import mtnt_pkg::*;

  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_NOTE      = 4'd2;
  localparam logic [3:0] PH_DATA_TWO  = 4'd3;
  localparam logic [3:0] PH_DATA_LAST = 4'd4;
  localparam logic [3:0] PH_SYSEX     = 4'd5;
  localparam logic [3:0] PH_META_TYPE = 4'd6;
  localparam logic [3:0] PH_META_LEN  = 4'd7;
  localparam logic [3:0] PH_META_SKIP = 4'd8;

  localparam logic [2:0] RC_NONE = 3'd0;
  localparam logic [2:0] RC_BEND = 3'd1;
  localparam logic [2:0] RC_ONE  = 3'd2;
  localparam logic [2:0] RC_MODE = 3'd3;
  localparam logic [2:0] RC_NOTE = 3'd4;

  logic [3:0]        phase_r, phase_nxt;
  logic [2:0]        rclass_r, rclass_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [SKIP_W-1:0] len_acc;
  logic [SKIP_W-1:0] skip_dec;
  byte_t             shifted;

  assign shifted  = byte_in + note_shift;
  assign len_acc  = {skip_r[SKIP_W-8:0], byte_in[6:0]};
  assign skip_dec = skip_r - SKIP_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    rclass_nxt   = rclass_r;
    skip_nxt     = skip_r;
    res.byte_val = byte_in;
    res.was_note = 1'b0;
    unique case (phase_r)
      PH_DELTA: phase_nxt = byte_in[7] ? PH_DELTA : PH_STATUS;
      PH_STATUS: begin
        if (byte_in == ST_META) begin
          phase_nxt = PH_META_TYPE;
        end else begin
          unique case (byte_in[7:4]) inside
            NIB_SYS: phase_nxt = PH_SYSEX;
            NIB_BEND: begin
              rclass_nxt = RC_BEND;
              phase_nxt  = PH_DATA_TWO;
            end
            NIB_CHPRESS, NIB_PROG: begin
              rclass_nxt = RC_ONE;
              phase_nxt  = PH_DATA_LAST;
            end
            NIB_CTRL: begin
              rclass_nxt = RC_MODE;
              phase_nxt  = PH_DATA_TWO;
            end
            NIB_POLY, NIB_NOTE_ON, NIB_NOTE_OFF: begin
              rclass_nxt = RC_NOTE;
              phase_nxt  = PH_NOTE;
            end
            default: begin
              // running status: this byte is the first data byte
              unique case (rclass_r)
                RC_BEND, RC_MODE: phase_nxt = PH_DATA_LAST;
                RC_NOTE: begin
                  res.byte_val = shifted;
                  res.was_note = 1'b1;
                  phase_nxt    = PH_DATA_LAST;
                end
                default: phase_nxt = PH_DELTA;
              endcase
            end
          endcase
        end
      end
      PH_NOTE: begin
        res.byte_val = shifted;
        res.was_note = 1'b1;
        phase_nxt    = PH_DATA_LAST;
      end
      PH_DATA_TWO:  phase_nxt = PH_DATA_LAST;
      PH_DATA_LAST: phase_nxt = PH_DELTA;
      PH_SYSEX:     phase_nxt = (byte_in == ST_SYSEX_END) ? PH_DELTA : PH_SYSEX;
      PH_META_TYPE: begin
        skip_nxt  = '0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN: begin
        skip_nxt = len_acc;
        if (byte_in[7]) begin
          phase_nxt = PH_META_LEN;
        end else begin
          phase_nxt = (len_acc == '0) ? PH_DELTA : PH_META_SKIP;
        end
      end
      PH_META_SKIP: begin
        skip_nxt  = skip_dec;
        phase_nxt = (skip_dec == '0) ? PH_DELTA : PH_META_SKIP;
      end
      default: phase_nxt = PH_DELTA;
    endcase
    if (last_in) begin
      phase_nxt = PH_DELTA;
      skip_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DELTA;
      rclass_r <= RC_NONE;
      skip_r   <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      rclass_r <= rclass_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/midi_track_note_transposer.sv
// ----------------------------------------------------------------------------
// midi_track_note_transposer: MIDI track byte stream note transposer
// Input register, parser, output register; note bytes get note_shift added.
// ----------------------------------------------------------------------------
// Each beat is captured in the input register, then in the output register.
// Throughput: one beat per cycle unless out_ready stalls, one parser step per byte.
// Reset (rst_n low, synchronous): both pipeline stages empty, parser to
// delta-time phase with no running status, note_shift to 0.
`default_nettype none

module midi_track_note_transposer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire mtnt_pkg::byte_t  cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mtnt_pkg::byte_t  in_byte_in,
  input  wire logic             in_last_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mtnt_pkg::byte_t       out_byte_out,
  output logic                  out_was_note,
  output logic                  out_last_out
);
  import mtnt_pkg::*;

  logic      shift_r;
  byte_t     note_shift_r;
  logic      s1_valid_r;
  byte_t     s1_byte_r;
  logic      s1_last_r;
  logic      o_valid_r;
  mtnt_res_t o_res_r;
  logic      o_last_r;
  logic      o_free;
  logic      s1_move;
  mtnt_res_t res;

  assign o_free   = !o_valid_r || out_ready;
  assign s1_move  = s1_valid_r && o_free;
  assign in_ready = !s1_valid_r || o_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_shift_r <= '0;
      shift_r      <= 1'b0;
    end else begin
      shift_r <= cfg_we;
      if (cfg_we) note_shift_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_last_byte;
    end
  end

  mtnt_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_move),
    .byte_in    (s1_byte_r),
    .last_in    (s1_last_r),
    .note_shift (note_shift_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_free) begin
      o_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_res_r  <= res;
      o_last_r <= s1_last_r;
    end
  end

  assign out_valid    = o_valid_r;
  assign out_byte_out = o_res_r.byte_val;
  assign out_was_note = o_res_r.was_note;
  assign out_last_out = o_last_r;

  // input stalls only when both stages hold beats and the sink is blocked
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && o_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  // a beat leaving the input register always lands in the output register
  a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> o_valid_r)
    else $error("beat lost between stages");

  // config write takes effect on the next edge
  a_cfg_applied: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r |-> note_shift_r == $past(cfg_wdata))
    else $error("note shift not loaded");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!o_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
